### sv/assert_macros.svh
// Assertion helpers, clocked on clk and quiet while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define MF_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define MF_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### sv/mf_pkg.sv
package mf_pkg;

	localparam int NWIN = 9;
	localparam int MED_IDX = 4;

	typedef enum logic [1:0] {
		MODE_GREY = 2'd0,
		MODE_RGB  = 2'd1,
		MODE_INT  = 2'd2
	} mode_t;

	typedef enum logic [1:0] {
		REG_MODE   = 2'd0,
		REG_WIDTH  = 2'd1,
		REG_HEIGHT = 2'd2
	} cfg_reg_t;

	typedef logic [NWIN-1:0][31:0] vec9_t;

	typedef struct packed {
		logic [10:0] col;
		logic [15:0] row;
		logic        done;
	} tag_t;

	// returns {high, low}; byte lanes sort independently in colour modes
	function automatic logic [63:0] cswap(input logic [31:0] a, input logic [31:0] b,
		input logic int_mode);
		logic [31:0] lo;
		logic [31:0] hi;
		lo = a;
		hi = b;
		if (int_mode) begin
			if ($signed(a) > $signed(b)) begin
				lo = b;
				hi = a;
			end
		end else begin
			for (int l = 0; l < 4; l++) begin
				if (a[8*l +: 8] > b[8*l +: 8]) begin
					lo[8*l +: 8] = b[8*l +: 8];
					hi[8*l +: 8] = a[8*l +: 8];
				end else begin
					lo[8*l +: 8] = a[8*l +: 8];
					hi[8*l +: 8] = b[8*l +: 8];
				end
			end
		end
		return {hi, lo};
	endfunction

endpackage

### sv/median3x3_filter.sv
// Channel  | Dir | Fields (low bit first)
// s_*      | in  | tdata: red_in, green_in, blue_in, int_in
// m_*      | out | tdata: red, green, blue, int, column, row; tlast: frame_done
// cfg_*    | in  | index 0 pixel_mode, 1 image_width, 2 image_height
// One pixel per clock inside a row while s_tready is high. A row-end pixel gives up
// to two results and a last-row pixel up to four; the sort chain takes one result a
// clock unless frozen, so extra results pile up in the 4-entry job queue and s_tready
// drops once it is full. From accept to m_tvalid: line RAM read, queue, nine sort
// cells. Reset clears counters and control only; line RAM needs no clearing pass.
// A stalled m_tvalid beat freezes the sort chain; input stops once the queue fills.
module median3x3_filter import mf_pkg::*; #(
	parameter int MAX_WIDTH = 2048
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [55:0] s_tdata,   // red_in, green_in, blue_in, int_in
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [87:0] m_tdata,   // red, green, blue, int, column, row, zero pad
	output logic        m_tlast,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int WW = CW + 1;

	typedef struct packed {
		vec9_t         win;
		logic [CW-1:0] c;
		logic [15:0]   r;
		logic [3:0]    jobs;
	} entry_t;

	logic [1:0]    mode_q;
	logic [11:0]   width_q;
	logic [15:0]   height_q;
	logic [CW-1:0] col_q;
	logic [15:0]   row_q;

	logic          int_mode;
	logic [WW-1:0] wc;
	logic [15:0]   hc;
	logic [CW-1:0] c;
	logic [15:0]   r;
	logic          row_end;
	logic          last_row;
	logic          accept;
	logic [31:0]   pix;

	logic          s1_v_q;
	logic [31:0]   pix_s1;
	logic [CW-1:0] c_s1;
	logic [15:0]   r_s1;
	logic [3:0]    jobs_s1;
	logic          fwd_s1;
	logic [63:0]   fwdd_s1;
	logic [63:0]   ram_q;
	logic [63:0]   ld;
	logic [31:0]   top;
	logic [31:0]   mid;
	vec9_t         win_q;
	vec9_t         win_d;

	entry_t        fifo_q [4];
	logic [1:0]    wr_q;
	logic [1:0]    rd_q;
	logic [2:0]    cnt_q;
	logic [3:0]    used_q;
	entry_t        head;
	logic [3:0]    rem;
	logic [3:0]    bit_k;
	logic [1:0]    k;
	logic          issue;
	logic          pop;
	logic          en;
	logic          kedge;
	logic          kflush;
	vec9_t         jv;
	tag_t          jt;

	logic          cv [10];
	vec9_t         cd [10];
	tag_t          ct [10];
	logic [31:0]   med;

	assign int_mode = !(mode_q == MODE_GREY || mode_q == MODE_RGB);

	// effective frame size and position
	always_comb begin
		if (width_q == 12'd0) begin
			wc = WW'(1);
		end else if (32'(width_q) > MAX_WIDTH) begin
			wc = WW'(MAX_WIDTH);
		end else begin
			wc = WW'(width_q);
		end
		hc = (height_q == 16'd0) ? 16'd1 : height_q;
		c = ({1'b0, col_q} >= wc) ? CW'(wc - WW'(1)) : col_q;
		r = (row_q >= hc) ? hc - 16'd1 : row_q;
		row_end = ({1'b0, c} == wc - WW'(1));
		last_row = (r == hc - 16'd1);
		pix = int_mode ? s_tdata[55:24] : {8'd0, s_tdata[23:0]};
	end

	assign s_tready = ({1'b0, cnt_q} + {3'd0, s1_v_q}) < 4'd4;
	assign accept = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_GREY;
			width_q <= 12'd640;
			height_q <= 16'd480;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_MODE:   mode_q <= cfg_data[1:0];
				REG_WIDTH:  width_q <= cfg_data[11:0];
				REG_HEIGHT: height_q <= cfg_data;
				default:    ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
			s1_v_q <= 1'b0;
		end else begin
			s1_v_q <= accept;
			if (accept) begin
				if (row_end) begin
					col_q <= '0;
					row_q <= last_row ? 16'd0 : r + 16'd1;
				end else begin
					col_q <= c + CW'(1);
					row_q <= r;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pix_s1 <= pix;
			c_s1 <= c;
			r_s1 <= r;
			jobs_s1 <= {last_row && row_end, last_row && c != '0,
				r != 16'd0 && row_end, r != 16'd0 && c != '0};
			// line RAM reads the old word when the previous pixel writes the same column
			fwd_s1 <= s1_v_q && c_s1 == c;
			fwdd_s1 <= {ld[31:0], pix_s1};
		end
	end

	mf_ram #(.WIDTH(64), .DEPTH(MAX_WIDTH)) u_lines (
		.clk   (clk),
		.we    (s1_v_q),
		.waddr (c_s1),
		.wdata ({ld[31:0], pix_s1}),
		.raddr (c),
		.rdata (ram_q)
	);

	// ld: older row in the upper word, newer row in the lower
	always_comb begin
		ld = fwd_s1 ? fwdd_s1 : ram_q;
		if (r_s1 == 16'd0) begin
			top = pix_s1;
			mid = pix_s1;
		end else if (r_s1 == 16'd1) begin
			top = ld[31:0];
			mid = ld[31:0];
		end else begin
			top = ld[63:32];
			mid = ld[31:0];
		end
		if (c_s1 == '0) begin
			for (int a = 0; a < 3; a++) begin
				win_d[a*3]   = top;
				win_d[a*3+1] = mid;
				win_d[a*3+2] = pix_s1;
			end
		end else begin
			for (int a = 0; a < 6; a++) begin
				win_d[a] = win_q[a+3];
			end
			win_d[6] = top;
			win_d[7] = mid;
			win_d[8] = pix_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_v_q) begin
			win_q <= win_d;
			fifo_q[wr_q] <= '{win: win_d, c: c_s1, r: r_s1, jobs: jobs_s1};
		end
	end

	// job queue head: one result window per clock into the sort chain unless it is frozen
	assign en = !cv[9] || m_tready;

	always_comb begin
		head = fifo_q[rd_q];
		rem = head.jobs & ~used_q;
		k = 2'd3;
		for (int i = 3; i >= 0; i--) begin
			if (rem[i]) begin
				k = 2'(i);
			end
		end
		bit_k = 4'd1 << k;
		issue = cnt_q != 3'd0 && rem != 4'd0 && en;
		pop = cnt_q != 3'd0 && (rem == 4'd0 || (issue && (rem & ~bit_k) == 4'd0));
		kedge = k[0];
		kflush = k[1];
		for (int a = 0; a < 3; a++) begin
			for (int b = 0; b < 3; b++) begin
				jv[a*3+b] = head.win[
					(kedge ? ((a == 0) ? 1 : 2) : a) * 3 +
					(kflush ? ((b == 0) ? 1 : 2) : b)];
			end
		end
		jt.col = 11'(kedge ? head.c : head.c - CW'(1));
		jt.row = kflush ? head.r : head.r - 16'd1;
		jt.done = (k == 2'd3);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
			used_q <= '0;
		end else begin
			if (s1_v_q) begin
				wr_q <= wr_q + 2'd1;
			end
			if (pop) begin
				rd_q <= rd_q + 2'd1;
				used_q <= '0;
			end else if (issue) begin
				used_q <= used_q | bit_k;
			end
			cnt_q <= cnt_q + {2'd0, s1_v_q} - {2'd0, pop};
		end
	end

	assign cv[0] = issue;
	assign cd[0] = jv;
	assign ct[0] = jt;

	for (genvar i = 0; i < NWIN; i++) begin : g_cell
		mf_cell #(.ODD(1'(i % 2))) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.int_mode (int_mode),
			.vin      (cv[i]),
			.din      (cd[i]),
			.tin      (ct[i]),
			.vout     (cv[i+1]),
			.dout     (cd[i+1]),
			.tout     (ct[i+1])
		);
	end

	always_comb begin
		med = cd[NWIN][MED_IDX];
		m_tdata = '0;
		m_tdata[82:56] = {ct[NWIN].row, ct[NWIN].col};
		if (int_mode) begin
			m_tdata[55:24] = med;
		end else if (mode_q == MODE_GREY) begin
			m_tdata[23:0] = {3{med[7:0]}};
		end else begin
			m_tdata[23:0] = med[23:0];
		end
	end

	assign m_tvalid = cv[NWIN];
	assign m_tlast = ct[NWIN].done;

endmodule

### sv/mf_ram.sv
module mf_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

### sv/mf_cell.sv
// One odd-even transposition round; nine in a row fully sort the window.
module mf_cell import mf_pkg::*; #(
	parameter bit ODD = 1'b0
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  en,
	input  logic  int_mode,
	input  logic  vin,
	input  vec9_t din,
	input  tag_t  tin,
	output logic  vout,
	output vec9_t dout,
	output tag_t  tout
);

	vec9_t d;
	logic  v_q;
	vec9_t d_q;
	tag_t  t_q;

	always_comb begin
		d = din;
		for (int p = 0; p < 4; p++) begin
			{d[2*p+int'(ODD)+1], d[2*p+int'(ODD)]} =
				cswap(din[2*p+int'(ODD)], din[2*p+int'(ODD)+1], int_mode);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (en) begin
			v_q <= vin;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_q <= d;
			t_q <= tin;
		end
	end

	assign vout = v_q;
	assign dout = d_q;
	assign tout = t_q;

endmodule

### sv/mf_checker.sv
`include "assert_macros.svh"

module mf_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [87:0] m_tdata,
	input logic        m_tlast
);

	`MF_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready,
		m_tvalid && $stable(m_tdata) && $stable(m_tlast), "output beat changed while stalled")
	`MF_ASSERT_IMPL(a_int_excl, m_tvalid && m_tdata[55:24] != 32'd0,
		m_tdata[23:0] == 24'd0, "integer and colour medians both nonzero")
	`MF_ASSERT_IMPL(a_pad_zero, m_tvalid, m_tdata[87:83] == 5'd0, "tdata pad bits set")

endmodule

bind median3x3_filter mf_checker u_mf_checker (.*);
